@@ hdl/tsg_pkg.sv @@
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, register codes and widths of the triangle span generator.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int COORD_BITS = 16;
  localparam int DIM_W      = 13;
  localparam int ROW_W      = 12;
  localparam int VAL_W      = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERP_MODE  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(1024);
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(MAX_DIM);

  // divider: radix-16 restoring, one quotient nibble per stage
  localparam int DIV_NUM_W  = 52;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = DIV_NUM_W / DIV_BITS;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] vertex_a_x;
    logic signed [COORD_BITS-1:0] vertex_a_y;
    logic signed [COORD_BITS-1:0] vertex_b_x;
    logic signed [COORD_BITS-1:0] vertex_b_y;
    logic signed [COORD_BITS-1:0] vertex_c_x;
    logic signed [COORD_BITS-1:0] vertex_c_y;
    logic signed [VAL_W-1:0]      vertex_a_value;
    logic signed [VAL_W-1:0]      vertex_b_value;
    logic signed [VAL_W-1:0]      vertex_c_value;
    logic [ROW_W-1:0]             row;
  } tri_t;

  typedef struct packed {
    logic                    span_valid;
    logic [DIM_W-1:0]        span_start;
    logic [DIM_W-1:0]        span_end;
    logic signed [VAL_W-1:0] start_value;
    logic signed [VAL_W-1:0] value_step;
  } span_t;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             interp;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [VAL_W-1:0]      v;
    logic [1:0]                   idx;
  } vtx_t;

  // both edges crossing the row
  typedef struct packed {
    logic                    vld;
    logic                    rej;
    logic signed [17:0]      xa;
    logic signed [33:0]      va;
    logic signed [17:0]      xb;
    logic signed [33:0]      vb;
    logic signed [VAL_W-1:0] v0;
  } edge_t;

  function automatic logic [DIV_NUM_W-1:0] mag_of(logic signed [DIV_NUM_W-1:0] n);
    return n[DIV_NUM_W-1] ? DIV_NUM_W'(-n) : DIV_NUM_W'(n);
  endfunction

endpackage

@@ hdl/tsg_if.sv @@
// ----------------------------------------------------------------------------
// tsg interfaces
// Valid/ready channels for triangles, spans and register writes.
// ----------------------------------------------------------------------------
interface tsg_in_if import tsg_pkg::*; ();
  logic valid;
  logic ready;
  tri_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsg_out_if import tsg_pkg::*; ();
  logic  valid;
  logic  ready;
  span_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tsg_cfg_if import tsg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/triangle_span_generator_unit.sv @@
// ----------------------------------------------------------------------------
// triangle_span_generator_unit
// Throughput: one triangle per cycle while the output is not stalled. The
// pipeline holds two chains of 13-stage radix-16 dividers (edge
// intersection, then step and start value).
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits and loads width 1024, height 1024, interpolate.
// ----------------------------------------------------------------------------
module triangle_span_generator_unit import tsg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  tsg_in_if.sink     tri_i,
  tsg_cfg_if.sink    cfg_i,
  tsg_out_if.source  span_o
);

  logic [DIM_W-1:0] width_q, height_q;
  logic             interp_q;
  cfg_t             cfg;
  logic             adv;
  logic             out_vld;
  span_t            out_res;
  edge_t            edge_s;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_RESET;
      height_q <= DIM_RESET;
      interp_q <= 1'b1;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        CFG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        CFG_INTERP_MODE:  interp_q <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // widths and heights above the maximum image size act as the maximum
  assign cfg.width  = (width_q > DIM_LIMIT) ? DIM_LIMIT : width_q;
  assign cfg.height = (height_q > DIM_LIMIT) ? DIM_LIMIT : height_q;
  assign cfg.interp = interp_q;

  assign adv         = !out_vld || span_o.ready;
  assign tri_i.ready = adv;

  tsg_edge u_edge (
    .clk_i,
    .rst_ni,
    .en_i     (adv),
    .in_vld_i (tri_i.valid),
    .in_i     (tri_i.data),
    .cfg_i    (cfg),
    .edge_o   (edge_s)
  );

  tsg_span u_span (
    .clk_i,
    .rst_ni,
    .en_i      (adv),
    .edge_i    (edge_s),
    .cfg_i     (cfg),
    .out_vld_o (out_vld),
    .out_o     (out_res)
  );

  assign span_o.valid = out_vld;
  assign span_o.data  = out_res;

`ifndef NO_ASSERTIONS
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && span_o.data.span_valid |->
      span_o.data.span_start < span_o.data.span_end)
    else $error("span start not below span end");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && !span_o.data.span_valid |->
      span_o.data.span_start == '0 && span_o.data.span_end == '0 &&
      span_o.data.start_value == '0 && span_o.data.value_step == '0)
    else $error("empty span carries nonzero fields");

  a_clip_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && span_o.data.span_valid |-> span_o.data.span_end <= cfg.width)
    else $error("span end beyond image width");

  a_flat_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    span_o.valid && !cfg.interp |-> span_o.data.value_step == '0)
    else $error("nonzero step in flat mode");
`endif

endmodule

@@ hdl/tsg_div.sv @@
// ----------------------------------------------------------------------------
// tsg_div
// Pipelined unsigned divider, four quotient bits per register stage.
// ----------------------------------------------------------------------------
module tsg_div import tsg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_NUM_W-1:0] quo_o
);

  typedef struct packed {
    logic [DIV_DEN_W-1:0] rem;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_NUM_W-1:0] quo;
    logic [DIV_DEN_W-1:0] den;
  } div_st_t;

  function automatic div_st_t div_step(div_st_t s);
    div_st_t          o;
    logic [DIV_DEN_W:0] trial;
    o = s;
    for (int b = 0; b < DIV_BITS; b++) begin
      trial = {o.rem, o.num[DIV_NUM_W-1]};
      o.num = {o.num[DIV_NUM_W-2:0], 1'b0};
      if (trial >= {1'b0, o.den}) begin
        o.rem = DIV_DEN_W'(trial - {1'b0, o.den});
        o.quo = {o.quo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        o.rem = trial[DIV_DEN_W-1:0];
        o.quo = {o.quo[DIV_NUM_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  div_st_t st_q [DIV_STAGES];
  div_st_t st_d [DIV_STAGES];
  div_st_t first;

  always_comb begin
    first.rem = '0;
    first.num = num_i;
    first.quo = '0;
    first.den = den_i;
    st_d[0] = div_step(first);
    for (int k = 1; k < DIV_STAGES; k++) begin
      st_d[k] = div_step(st_q[k-1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= st_d;
    end
  end

  assign quo_o = st_q[DIV_STAGES-1].quo;

endmodule

@@ hdl/tsg_edge.sv @@
// ----------------------------------------------------------------------------
// tsg_edge
// Vertex sort, trivial reject, row-to-half selection and the exact
// intersection of the long and short edge with the row.
// ----------------------------------------------------------------------------
module tsg_edge import tsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  in_vld_i,
  input  tri_t  in_i,
  input  cfg_t  cfg_i,
  output edge_t edge_o
);

  function automatic logic vtx_before(vtx_t p, vtx_t q);
    return (p.y < q.y) || ((p.y == q.y) && (p.idx > q.idx));
  endfunction

  // ---------------- stage 1: sort and bounding reject
  vtx_t       vin [3];
  vtx_t       lo, mi, hi, tmp;
  logic [2:0] xn, xw, yn, yh;
  logic       rej1;

  always_comb begin
    vin[0] = '{x: in_i.vertex_a_x, y: in_i.vertex_a_y, v: in_i.vertex_a_value, idx: 2'd0};
    vin[1] = '{x: in_i.vertex_b_x, y: in_i.vertex_b_y, v: in_i.vertex_b_value, idx: 2'd1};
    vin[2] = '{x: in_i.vertex_c_x, y: in_i.vertex_c_y, v: in_i.vertex_c_value, idx: 2'd2};
    for (int i = 0; i < 3; i++) begin
      xn[i] = vin[i].x[COORD_BITS-1];
      yn[i] = vin[i].y[COORD_BITS-1];
      xw[i] = $signed({vin[i].x[COORD_BITS-1], vin[i].x}) >= $signed({4'b0, cfg_i.width});
      yh[i] = $signed({vin[i].y[COORD_BITS-1], vin[i].y}) >= $signed({4'b0, cfg_i.height});
    end
    rej1 = (&xn) | (&xw) | (&yn) | (&yh);
    tmp = vin[0];
    lo = vin[0];
    mi = vin[1];
    hi = vin[2];
    if (vtx_before(mi, lo)) begin
      tmp = lo; lo = mi; mi = tmp;
    end
    if (vtx_before(hi, mi)) begin
      tmp = mi; mi = hi; hi = tmp;
    end
    if (vtx_before(mi, lo)) begin
      tmp = lo; lo = mi; mi = tmp;
    end
  end

  logic                    s1_vld_q;
  vtx_t                    s1_lo_q, s1_mi_q, s1_hi_q;
  logic [ROW_W-1:0]        s1_row_q;
  logic signed [VAL_W-1:0] s1_v0_q;
  logic                    s1_rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en_i) begin
      s1_vld_q <= in_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_lo_q  <= lo;
      s1_mi_q  <= mi;
      s1_hi_q  <= hi;
      s1_row_q <= in_i.row;
      s1_v0_q  <= in_i.vertex_a_value;
      s1_rej_q <= rej1;
    end
  end

  // ---------------- stage 2: half select and edge products
  logic signed [17:0] y1e, y2e, y3e, re;
  logic               lower, upper, rej2;
  logic [15:0]        dl, tl, ds, ts;
  vtx_t               sp, sq;
  logic signed [16:0] dxl, dxs;
  logic signed [32:0] dvl, dvs;
  logic signed [32:0] pxl0, pxs0;
  logic signed [33:0] pxl1, pxs1;
  logic signed [49:0] pvl, pvs;

  always_comb begin
    y1e   = 18'(s1_lo_q.y);
    y2e   = 18'(s1_mi_q.y);
    y3e   = 18'(s1_hi_q.y);
    re    = $signed({6'b0, s1_row_q});
    lower = (re >= y1e) && (re < y2e);
    upper = (re >= y2e) && (re < y3e);
    rej2  = s1_rej_q | (s1_lo_q.y == s1_hi_q.y) | ({1'b0, s1_row_q} >= cfg_i.height)
          | !(lower | upper);
    dl    = 16'(y3e - y1e);
    tl    = 16'(re - y1e);
    ds    = lower ? 16'(y2e - y1e) : 16'(y3e - y2e);
    ts    = lower ? tl : 16'(re - y2e);
    sp    = lower ? s1_lo_q : s1_mi_q;
    sq    = lower ? s1_mi_q : s1_hi_q;
    dxl   = 17'(s1_hi_q.x) - 17'(s1_lo_q.x);
    dxs   = 17'(sq.x) - 17'(sp.x);
    dvl   = 33'(s1_hi_q.v) - 33'(s1_lo_q.v);
    dvs   = 33'(sq.v) - 33'(sp.v);
    pxl0  = s1_lo_q.x * $signed({1'b0, dl});
    pxs0  = sp.x * $signed({1'b0, ds});
    pxl1  = dxl * $signed({1'b0, tl});
    pxs1  = dxs * $signed({1'b0, ts});
    pvl   = dvl * $signed({1'b0, tl});
    pvs   = dvs * $signed({1'b0, ts});
  end

  logic                    s2_vld_q;
  logic signed [32:0]      s2_pxl0_q, s2_pxs0_q;
  logic signed [33:0]      s2_pxl1_q, s2_pxs1_q;
  logic signed [49:0]      s2_pvl_q, s2_pvs_q;
  logic [15:0]             s2_dl_q, s2_ds_q;
  logic signed [VAL_W-1:0] s2_v1_q, s2_pv_q, s2_v0_q;
  logic                    s2_rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en_i) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_pxl0_q <= pxl0;
      s2_pxs0_q <= pxs0;
      s2_pxl1_q <= pxl1;
      s2_pxs1_q <= pxs1;
      s2_pvl_q  <= pvl;
      s2_pvs_q  <= pvs;
      s2_dl_q   <= dl;
      s2_ds_q   <= ds;
      s2_v1_q   <= s1_lo_q.v;
      s2_pv_q   <= sp.v;
      s2_v0_q   <= s1_v0_q;
      s2_rej_q  <= rej2;
    end
  end

  // ---------------- stage 3: numerators to sign and magnitude
  logic signed [34:0] nxl, nxs;

  assign nxl = 35'(s2_pxl0_q) + 35'(s2_pxl1_q);
  assign nxs = 35'(s2_pxs0_q) + 35'(s2_pxs1_q);

  logic                    s3_vld_q;
  logic [DIV_NUM_W-1:0]    s3_mxl_q, s3_mvl_q, s3_mxs_q, s3_mvs_q;
  logic [3:0]              s3_sgn_q;
  logic [15:0]             s3_dl_q, s3_ds_q;
  logic signed [VAL_W-1:0] s3_v1_q, s3_pv_q, s3_v0_q;
  logic                    s3_rej_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en_i) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_mxl_q <= mag_of(DIV_NUM_W'(nxl));
      s3_mvl_q <= mag_of(DIV_NUM_W'(s2_pvl_q));
      s3_mxs_q <= mag_of(DIV_NUM_W'(nxs));
      s3_mvs_q <= mag_of(DIV_NUM_W'(s2_pvs_q));
      s3_sgn_q <= {s2_pvs_q[49], nxs[34], s2_pvl_q[49], nxl[34]};
      s3_dl_q  <= s2_dl_q;
      s3_ds_q  <= s2_ds_q;
      s3_v1_q  <= s2_v1_q;
      s3_pv_q  <= s2_pv_q;
      s3_v0_q  <= s2_v0_q;
      s3_rej_q <= s2_rej_q;
    end
  end

  // ---------------- edge dividers
  logic [DIV_NUM_W-1:0] q_xl, q_vl, q_xs, q_vs;

  tsg_div u_div_xl (.clk_i, .en_i, .num_i(s3_mxl_q), .den_i(s3_dl_q), .quo_o(q_xl));
  tsg_div u_div_vl (.clk_i, .en_i, .num_i(s3_mvl_q), .den_i(s3_dl_q), .quo_o(q_vl));
  tsg_div u_div_xs (.clk_i, .en_i, .num_i(s3_mxs_q), .den_i(s3_ds_q), .quo_o(q_xs));
  tsg_div u_div_vs (.clk_i, .en_i, .num_i(s3_mvs_q), .den_i(s3_ds_q), .quo_o(q_vs));

  typedef struct packed {
    logic                    rej;
    logic [3:0]              sgn;
    logic signed [VAL_W-1:0] v1;
    logic signed [VAL_W-1:0] pv;
    logic signed [VAL_W-1:0] v0;
  } side_t;

  logic [DIV_STAGES-1:0] dv_vld_q;
  side_t                 side_q [DIV_STAGES];
  side_t                 sd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en_i) begin
      dv_vld_q <= {dv_vld_q[DIV_STAGES-2:0], s3_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{rej: s3_rej_q, sgn: s3_sgn_q, v1: s3_v1_q, pv: s3_pv_q, v0: s3_v0_q};
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign sd = side_q[DIV_STAGES-1];

  // ---------------- stage 4: signed edge x and value
  logic signed [17:0] qxl, qxs, xa, xb;
  logic signed [33:0] qvl, qvs, va, vb;

  always_comb begin
    qxl = $signed({1'b0, q_xl[16:0]});
    qxs = $signed({1'b0, q_xs[16:0]});
    qvl = $signed({1'b0, q_vl[32:0]});
    qvs = $signed({1'b0, q_vs[32:0]});
    xa  = sd.sgn[0] ? -qxl : qxl;
    xb  = sd.sgn[2] ? -qxs : qxs;
    va  = 34'(sd.v1) + (sd.sgn[1] ? -qvl : qvl);
    vb  = 34'(sd.pv) + (sd.sgn[3] ? -qvs : qvs);
  end

  logic                    e_vld_q, e_rej_q;
  logic signed [17:0]      e_xa_q, e_xb_q;
  logic signed [33:0]      e_va_q, e_vb_q;
  logic signed [VAL_W-1:0] e_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (en_i) begin
      e_vld_q <= dv_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      e_rej_q <= sd.rej;
      e_xa_q  <= xa;
      e_xb_q  <= xb;
      e_va_q  <= va;
      e_vb_q  <= vb;
      e_v0_q  <= sd.v0;
    end
  end

  assign edge_o = '{vld: e_vld_q, rej: e_rej_q, xa: e_xa_q, va: e_va_q,
                    xb: e_xb_q, vb: e_vb_q, v0: e_v0_q};

endmodule

@@ hdl/tsg_span.sv @@
// ----------------------------------------------------------------------------
// tsg_span
// Left/right ordering, horizontal clip, per-pixel step and start value.
// ----------------------------------------------------------------------------
module tsg_span import tsg_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  edge_t edge_i,
  input  cfg_t  cfg_i,
  output logic  out_vld_o,
  output span_t out_o
);

  // ---------------- stage 1: order and clip
  logic signed [17:0] xl, xr, w18, sx, ex;
  logic signed [33:0] vl, vr;
  logic               take_a, clip_ok, rej;

  always_comb begin
    take_a  = edge_i.xa < edge_i.xb;
    xl      = take_a ? edge_i.xa : edge_i.xb;
    xr      = take_a ? edge_i.xb : edge_i.xa;
    vl      = take_a ? edge_i.va : edge_i.vb;
    vr      = take_a ? edge_i.vb : edge_i.va;
    w18     = $signed({5'b0, cfg_i.width});
    clip_ok = (xl < w18) && (xr > 18'sd0);
    sx      = (xl < 18'sd0) ? 18'sd0 : xl;
    ex      = (xr > w18) ? w18 : xr;
    rej     = edge_i.rej | !clip_ok | (sx >= ex);
  end

  logic                    c_vld_q, c_rej_q;
  logic signed [17:0]      c_xl_q, c_xr_q;
  logic signed [33:0]      c_vl_q, c_vr_q;
  logic [DIM_W-1:0]        c_sx_q, c_ex_q;
  logic signed [VAL_W-1:0] c_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (en_i) begin
      c_vld_q <= edge_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_rej_q <= rej;
      c_xl_q  <= xl;
      c_xr_q  <= xr;
      c_vl_q  <= vl;
      c_vr_q  <= vr;
      c_sx_q  <= sx[DIM_W-1:0];
      c_ex_q  <= ex[DIM_W-1:0];
      c_v0_q  <= edge_i.v0;
    end
  end

  // ---------------- stage 2: differences
  logic                    d_vld_q, d_rej_q;
  logic [15:0]             d_dxs_q, d_ofs_q;
  logic signed [34:0]      d_dv_q;
  logic signed [33:0]      d_vl_q;
  logic [DIM_W-1:0]        d_sx_q, d_ex_q;
  logic signed [VAL_W-1:0] d_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (en_i) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d_rej_q <= c_rej_q;
      d_dxs_q <= 16'(c_xr_q - c_xl_q);
      d_ofs_q <= 16'($signed({5'b0, c_sx_q}) - c_xl_q);
      d_dv_q  <= 35'(c_vr_q) - 35'(c_vl_q);
      d_vl_q  <= c_vl_q;
      d_sx_q  <= c_sx_q;
      d_ex_q  <= c_ex_q;
      d_v0_q  <= c_v0_q;
    end
  end

  // ---------------- stage 3: start offset product
  logic signed [51:0] prod;

  assign prod = d_dv_q * $signed({1'b0, d_ofs_q});

  logic                    m_vld_q, m_rej_q, m_dvs_q;
  logic signed [51:0]      m_prod_q;
  logic [DIV_NUM_W-1:0]    m_dvm_q;
  logic [15:0]             m_dxs_q;
  logic signed [33:0]      m_vl_q;
  logic [DIM_W-1:0]        m_sx_q, m_ex_q;
  logic signed [VAL_W-1:0] m_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (en_i) begin
      m_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_rej_q  <= d_rej_q;
      m_prod_q <= prod;
      m_dvm_q  <= mag_of(DIV_NUM_W'(d_dv_q));
      m_dvs_q  <= d_dv_q[34];
      m_dxs_q  <= d_dxs_q;
      m_vl_q   <= d_vl_q;
      m_sx_q   <= d_sx_q;
      m_ex_q   <= d_ex_q;
      m_v0_q   <= d_v0_q;
    end
  end

  // ---------------- stage 4: product magnitude
  logic                    a_vld_q, a_rej_q, a_dvs_q, a_ps_q;
  logic [DIV_NUM_W-1:0]    a_pm_q, a_dvm_q;
  logic [15:0]             a_dxs_q;
  logic signed [33:0]      a_vl_q;
  logic [DIM_W-1:0]        a_sx_q, a_ex_q;
  logic signed [VAL_W-1:0] a_v0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en_i) begin
      a_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_rej_q <= m_rej_q;
      a_pm_q  <= mag_of(m_prod_q);
      a_ps_q  <= m_prod_q[51];
      a_dvm_q <= m_dvm_q;
      a_dvs_q <= m_dvs_q;
      a_dxs_q <= m_dxs_q;
      a_vl_q  <= m_vl_q;
      a_sx_q  <= m_sx_q;
      a_ex_q  <= m_ex_q;
      a_v0_q  <= m_v0_q;
    end
  end

  // ---------------- step and start dividers
  logic [DIV_NUM_W-1:0] q_st, q_sv;

  tsg_div u_div_st (.clk_i, .en_i, .num_i(a_dvm_q), .den_i(a_dxs_q), .quo_o(q_st));
  tsg_div u_div_sv (.clk_i, .en_i, .num_i(a_pm_q), .den_i(a_dxs_q), .quo_o(q_sv));

  typedef struct packed {
    logic                    rej;
    logic                    dvs;
    logic                    ps;
    logic signed [33:0]      vl;
    logic [DIM_W-1:0]        sx;
    logic [DIM_W-1:0]        ex;
    logic signed [VAL_W-1:0] v0;
  } side_t;

  logic [DIV_STAGES-1:0] dv_vld_q;
  side_t                 side_q [DIV_STAGES];
  side_t                 sd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q <= '0;
    end else if (en_i) begin
      dv_vld_q <= {dv_vld_q[DIV_STAGES-2:0], a_vld_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{rej: a_rej_q, dvs: a_dvs_q, ps: a_ps_q, vl: a_vl_q,
                     sx: a_sx_q, ex: a_ex_q, v0: a_v0_q};
      for (int k = 1; k < DIV_STAGES; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign sd = side_q[DIV_STAGES-1];

  // ---------------- final stage: saturate, offset, flat mode, zero on reject
  logic signed [VAL_W-1:0] st;
  logic signed [35:0]      qsv, sum;
  span_t                   res;

  always_comb begin
    if (!sd.dvs) begin
      st = (q_st > DIV_NUM_W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_st[31:0]);
    end else begin
      st = (q_st > DIV_NUM_W'(32'h8000_0000)) ? 32'sh8000_0000
                                              : $signed(32'd0 - q_st[31:0]);
    end
    qsv = $signed({1'b0, q_sv[34:0]});
    sum = 36'(sd.vl) + (sd.ps ? -qsv : qsv);
    res = '0;
    if (!sd.rej) begin
      res.span_valid  = 1'b1;
      res.span_start  = sd.sx;
      res.span_end    = sd.ex;
      res.start_value = cfg_i.interp ? sum[VAL_W-1:0] : sd.v0;
      res.value_step  = cfg_i.interp ? st : '0;
    end
  end

  logic  f_vld_q;
  span_t f_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (en_i) begin
      f_vld_q <= dv_vld_q[DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_res_q <= res;
    end
  end

  assign out_vld_o = f_vld_q;
  assign out_o     = f_res_q;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Testbench of triangle_span_generator_unit. Triangles are sent on the input
// channel with random gaps and spans are taken with random stalls. A model of
// the span setup predicts each span, and every span is checked field by field
// in order. Register settings are changed between phases while the block is
// idle.
// ----------------------------------------------------------------------------
module tb;
  import tsg_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 40;
  localparam int LONG_HOLD      = 300;

  logic clk_i;
  logic rst_ni;

  tsg_in_if  tri_if ();
  tsg_cfg_if cfg_if ();
  tsg_out_if span_if ();

  triangle_span_generator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tri_i  (tri_if.sink),
    .cfg_i  (cfg_if.sink),
    .span_o (span_if.source)
  );

  // register copy used by the span model
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;
  logic             interp_reg;

  span_t pending_spans[$];
  int    n_errors;
  int    n_triangles;
  int    n_spans;
  int    n_covered;
  int    n_cfg_writes;
  int    idle_cycles;
  bit    gaps_on;
  bit    stalls_on;
  bit    long_hold_req;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic bit vertex_ahead(longint yi, longint yj, int i, int j);
    return (yi < yj) || (yi == yj && i > j);
  endfunction

  function automatic span_t predict_span(tri_t t);
    span_t  s;
    longint x[3];
    longint y[3];
    longint v[3];
    longint w, h, r;
    longint x1, x2, x3, y1, y2, y3, v1, v2, v3;
    longint xa, xb, va, vb, xl, xr, vl, vr, sx, ex, sv, st;
    int     lo, mi, hi, tmp;
    int     n_xneg, n_xw, n_yneg, n_yh;
    s = '0;
    w = (width_reg > DIM_LIMIT) ? MAX_DIM : longint'(width_reg);
    h = (height_reg > DIM_LIMIT) ? MAX_DIM : longint'(height_reg);
    r = longint'(t.row);
    x[0] = longint'(signed'(t.vertex_a_x));
    y[0] = longint'(signed'(t.vertex_a_y));
    x[1] = longint'(signed'(t.vertex_b_x));
    y[1] = longint'(signed'(t.vertex_b_y));
    x[2] = longint'(signed'(t.vertex_c_x));
    y[2] = longint'(signed'(t.vertex_c_y));
    v[0] = longint'(signed'(t.vertex_a_value));
    v[1] = longint'(signed'(t.vertex_b_value));
    v[2] = longint'(signed'(t.vertex_c_value));
    n_xneg = 0; n_xw = 0; n_yneg = 0; n_yh = 0;
    for (int i = 0; i < 3; i++) begin
      n_xneg += (x[i] < 0);
      n_xw   += (x[i] >= w);
      n_yneg += (y[i] < 0);
      n_yh   += (y[i] >= h);
    end
    if (n_xneg == 3 || n_xw == 3 || n_yneg == 3 || n_yh == 3) return s;
    lo = 0; mi = 1; hi = 2;
    if (vertex_ahead(y[mi], y[lo], mi, lo)) begin tmp = lo; lo = mi; mi = tmp; end
    if (vertex_ahead(y[hi], y[mi], hi, mi)) begin tmp = mi; mi = hi; hi = tmp; end
    if (vertex_ahead(y[mi], y[lo], mi, lo)) begin tmp = lo; lo = mi; mi = tmp; end
    x1 = x[lo]; x2 = x[mi]; x3 = x[hi];
    y1 = y[lo]; y2 = y[mi]; y3 = y[hi];
    v1 = v[lo]; v2 = v[mi]; v3 = v[hi];
    if (y1 == y3 || r >= h) return s;
    // long edge runs from lowest to highest vertex
    xa = (x1 * (y3 - y1) + (x3 - x1) * (r - y1)) / (y3 - y1);
    va = v1 + ((v3 - v1) * (r - y1)) / (y3 - y1);
    if (r >= y1 && r < y2) begin
      xb = (x1 * (y2 - y1) + (x2 - x1) * (r - y1)) / (y2 - y1);
      vb = v1 + ((v2 - v1) * (r - y1)) / (y2 - y1);
    end else if (r >= y2 && r < y3) begin
      xb = (x2 * (y3 - y2) + (x3 - x2) * (r - y2)) / (y3 - y2);
      vb = v2 + ((v3 - v2) * (r - y2)) / (y3 - y2);
    end else begin
      return s;
    end
    // on a tie the short edge is the left one
    if (xa < xb) begin
      xl = xa; vl = va; xr = xb; vr = vb;
    end else begin
      xl = xb; vl = vb; xr = xa; vr = va;
    end
    if (!(xl < w && xr > 0)) return s;
    sx = (xl < 0) ? 0 : xl;
    ex = (xr > w) ? w : xr;
    if (sx >= ex) return s;
    if (interp_reg) begin
      st = (vr - vl) / (xr - xl);
      if (st > 64'sd2147483647) st = 64'sd2147483647;
      if (st < -64'sd2147483648) st = -64'sd2147483648;
      sv = vl + ((vr - vl) * (sx - xl)) / (xr - xl);
    end else begin
      st = 0;
      sv = v[0];
    end
    s.span_valid  = 1'b1;
    s.span_start  = sx[DIM_W-1:0];
    s.span_end    = ex[DIM_W-1:0];
    s.start_value = sv[VAL_W-1:0];
    s.value_step  = st[VAL_W-1:0];
    return s;
  endfunction

  // all transactions are observed mid-cycle, where every signal is settled
  always @(negedge clk_i) begin
    span_t got;
    span_t exp_span;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        n_cfg_writes++;
        case (cfg_if.index)
          CFG_IMAGE_WIDTH:  width_reg  <= cfg_if.data;
          CFG_IMAGE_HEIGHT: height_reg <= cfg_if.data;
          CFG_INTERP_MODE:  interp_reg <= cfg_if.data[0];
          default: ;
        endcase
      end
      if (tri_if.valid && tri_if.ready) begin
        n_triangles++;
        pending_spans.push_back(predict_span(tri_if.data));
      end
      if (span_if.valid && span_if.ready) begin
        got = span_if.data;
        n_spans++;
        n_covered += got.span_valid;
        if (pending_spans.size() == 0) begin
          $display("%0t: span with nothing expected: %p", $time, got);
          n_errors++;
        end else begin
          exp_span = pending_spans.pop_front();
          if (got.span_valid !== exp_span.span_valid) begin
            $display("%0t: span_valid expected %0d actual %0d", $time,
                     exp_span.span_valid, got.span_valid);
            n_errors++;
          end
          if (got.span_start !== exp_span.span_start) begin
            $display("%0t: span_start expected %0d actual %0d", $time,
                     exp_span.span_start, got.span_start);
            n_errors++;
          end
          if (got.span_end !== exp_span.span_end) begin
            $display("%0t: span_end expected %0d actual %0d", $time,
                     exp_span.span_end, got.span_end);
            n_errors++;
          end
          if (got.start_value !== exp_span.start_value) begin
            $display("%0t: start_value expected %0d actual %0d", $time,
                     exp_span.start_value, got.start_value);
            n_errors++;
          end
          if (got.value_step !== exp_span.value_step) begin
            $display("%0t: value_step expected %0d actual %0d", $time,
                     exp_span.value_step, got.value_step);
            n_errors++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(negedge clk_i) begin
    if ((tri_if.valid && tri_if.ready) || (span_if.valid && span_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d spans outstanding", $time, pending_spans.size());
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // span receiver with random stalls and one long hold on request
  initial begin
    int n;
    span_if.ready <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      n = stalls_on ? $urandom_range(0, 8) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        n = LONG_HOLD;
      end
      if (n > 0) begin
        span_if.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      span_if.ready <= 1'b1;
      do @(negedge clk_i); while (!(span_if.valid && span_if.ready));
      @(posedge clk_i);
    end
  end

  task automatic send_triangle(tri_t t);
    int n;
    n = gaps_on ? $urandom_range(0, 8) : 0;
    if (n > 0) begin
      tri_if.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    tri_if.valid <= 1'b1;
    tri_if.data  <= t;
    do @(negedge clk_i); while (!tri_if.ready);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    tri_if.valid <= 1'b0;
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(negedge clk_i); while (!cfg_if.ready);
    @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_regs(int w, int h, bit interp);
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, DIM_W'(w));
    write_reg(CFG_IMAGE_HEIGHT, DIM_W'(h));
    write_reg(CFG_INTERP_MODE, DIM_W'(interp));
  endtask

  function automatic tri_t make_tri(int ax, int ay, int bx, int by, int cx, int cy,
                                    int av, int bv, int cv, int r);
    tri_t t;
    t.vertex_a_x = COORD_BITS'(ax); t.vertex_a_y = COORD_BITS'(ay);
    t.vertex_b_x = COORD_BITS'(bx); t.vertex_b_y = COORD_BITS'(by);
    t.vertex_c_x = COORD_BITS'(cx); t.vertex_c_y = COORD_BITS'(cy);
    t.vertex_a_value = av; t.vertex_b_value = bv; t.vertex_c_value = cv;
    t.row = ROW_W'(r);
    return t;
  endfunction

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // mostly triangles around the image with a row inside their y range
  function automatic tri_t rand_triangle();
    tri_t t;
    int   w, h, ymin, ymax, rlo, rhi;
    int   xs[3];
    int   ys[3];
    t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, ROW_W'($urandom)};
    if ($urandom_range(0, 9) == 0) return t;
    w = (width_reg > DIM_LIMIT) ? MAX_DIM : int'(width_reg);
    h = (height_reg > DIM_LIMIT) ? MAX_DIM : int'(height_reg);
    for (int i = 0; i < 3; i++) begin
      xs[i] = rand_between(-(w / 4) - 2, w + w / 4 + 2);
      ys[i] = rand_between(-(h / 4) - 2, h + h / 4 + 2);
    end
    if ($urandom_range(0, 7) == 0) ys[$urandom_range(0, 2)] = ys[$urandom_range(0, 2)];
    t.vertex_a_x = COORD_BITS'(xs[0]); t.vertex_a_y = COORD_BITS'(ys[0]);
    t.vertex_b_x = COORD_BITS'(xs[1]); t.vertex_b_y = COORD_BITS'(ys[1]);
    t.vertex_c_x = COORD_BITS'(xs[2]); t.vertex_c_y = COORD_BITS'(ys[2]);
    if ($urandom_range(0, 1) == 0) begin
      t.vertex_a_value = rand_between(-65536 * 256, 65536 * 256);
      t.vertex_b_value = rand_between(-65536 * 256, 65536 * 256);
      t.vertex_c_value = rand_between(-65536 * 256, 65536 * 256);
    end
    ymin = ys[0]; ymax = ys[0];
    for (int i = 1; i < 3; i++) begin
      if (ys[i] < ymin) ymin = ys[i];
      if (ys[i] > ymax) ymax = ys[i];
    end
    rlo = (ymin < 0) ? 0 : ymin;
    rhi = (ymax > 4095) ? 4095 : ymax;
    if (rlo <= rhi && $urandom_range(0, 7) != 0) t.row = ROW_W'(rand_between(rlo, rhi));
    return t;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_triangle(rand_triangle());
  endtask

  task automatic test_directed();
    // extremes and rejections at reset settings
    send_triangle(make_tri(-32768, -32768, 32767, 32767, 0, 100,
                           32'h80000000, 32'h7fffffff, 0, 50));
    send_triangle(make_tri(32767, 0, -32768, 500, 100, 1000,
                           32'h7fffffff, 32'h80000000, 12345, 4095));
    send_triangle(make_tri(-5, 0, -1, 50, -32768, 90, 1, 2, 3, 10));
    send_triangle(make_tri(1024, 0, 32767, 50, 2000, 90, 1, 2, 3, 10));
    send_triangle(make_tri(0, -1, 50, -32768, 90, -3, 1, 2, 3, 0));
    send_triangle(make_tri(0, 1024, 50, 32767, 90, 2000, 1, 2, 3, 1500));
    send_triangle(make_tri(0, 40, 500, 40, 900, 40, 1, 2, 3, 40));
    send_triangle(make_tri(0, 10, 500, 90, 900, 20, 1, 2, 3, 5));
    send_triangle(make_tri(0, 10, 500, 90, 900, 20, 1, 2, 3, 90));
    send_triangle(make_tri(0, 10, 500, 90, 900, 20, 1, 2, 3, 1024));
    // flat bottom and flat top, tie order among equal y
    send_triangle(make_tri(100, 10, 300, 10, 200, 80, 65536, -65536, 0, 10));
    send_triangle(make_tri(200, 10, 100, 80, 300, 80, 0, 65536, -65536, 79));
    send_triangle(make_tri(200, 50, 200, 50, 200, 90, 7, 8, 9, 60));
    // step saturation both ways on a one pixel span
    send_triangle(make_tri(0, 0, 1, 0, 0, 4, 32'h80000000, 32'h7fffffff, 0, 0));
    send_triangle(make_tri(0, 0, 1, 0, 0, 4, 32'h7fffffff, 32'h80000000, 0, 0));
    // span clipped on both sides
    send_triangle(make_tri(-3000, 0, 3000, 0, 0, 2000, -65536, 65536, 0, 300));
    send_triangle(make_tri(-100, 0, 2000, 700, 1500, 100, 1000, -1000, 5, 400));
    wait_idle();
    set_regs(16, 16, 0);
    send_triangle(make_tri(-3000, 0, 3000, 0, 0, 20, 32'h12345678, 1, 2, 5));
    send_triangle(make_tri(2, 0, 15, 15, 0, 15, -7, 7, 9, 15));
  endtask

  task automatic test_reg_sweep();
    set_regs(1024, 1024, 1);  send_random(30);
    set_regs(1, 1, 1);        send_random(25);
    set_regs(4096, 4096, 0);  send_random(30);
    set_regs(8191, 8191, 1);  send_random(30);
    set_regs(37, 19, 1);      send_random(30);
    set_regs(4096, 1, 0);     send_random(25);
    set_regs(1, 4096, 1);     send_random(25);
    set_regs(64, 48, 1);      send_random(25);
  endtask

  task automatic test_output_stall();
    set_regs(200, 200, 1);
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    send_random(90);
    gaps_on = 1'b1;
  endtask

  task automatic test_sender_pause();
    send_random(20);
    wait_idle();
    stalls_on = 1'b0;
    gaps_on = 1'b0;
    send_random(30);
    stalls_on = 1'b1;
    gaps_on = 1'b1;
    send_random(20);
  endtask

  initial begin
    width_reg     = DIM_RESET;
    height_reg    = DIM_RESET;
    interp_reg    = 1'b1;
    n_errors      = 0;
    n_triangles   = 0;
    n_spans       = 0;
    n_covered     = 0;
    n_cfg_writes  = 0;
    idle_cycles   = 0;
    gaps_on       = 1'b1;
    stalls_on     = 1'b1;
    long_hold_req = 1'b0;
    tri_if.valid <= 1'b0;
    tri_if.data  <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_IMAGE_WIDTH;
    cfg_if.data  <= '0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_reg_sweep();
    test_output_stall();
    test_sender_pause();
    wait_idle();

    $display("covered %0d triangles, %0d spans (%0d non-empty), %0d register writes",
             n_triangles, n_spans, n_covered, n_cfg_writes);
    $display("settings from 1x1 to beyond the size limit, flat and interpolated fill");
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/tsg_pkg.sv
hdl/tsg_if.sv
hdl/tsg_div.sv
hdl/tsg_edge.sv
hdl/tsg_span.sv
hdl/triangle_span_generator_unit.sv
bench/tb.sv
